FILE: sv/soil_pore_water_ec_convert_assert.svh
// Assertion shorthands for the pore water EC converter checks.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SOIL_PORE_WATER_EC_CONVERT_ASSERT_SVH
`define SOIL_PORE_WATER_EC_CONVERT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SPWEC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain condition checked at every clock edge outside reset.
`define SPWEC_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

FILE: sv/spwec_pkg.sv
package spwec_pkg;

    // field widths
    localparam int MOIST_W  = 10;
    localparam int TEMP_W   = 11;
    localparam int BULK_W   = 15;
    localparam int OFFS_W   = 15;
    localparam int CENTI_W  = 15;
    localparam int PERM_W   = 17;
    localparam int PORE_W   = 20;

    localparam int FRAC_BITS_DEF = 16;
    localparam logic [OFFS_W-1:0] OFFSET_RESET = 15'd4100;

    localparam logic [PORE_W-1:0] PORE_MAX = 20'hFFFFF;

    // quotient bits, one per divider stage
    localparam int DIV_BITS   = PORE_W;
    // 5 front stages, the divider, one output stage
    localparam int PIPE_DEPTH = DIV_BITS + 6;

    // permittivity: eps_b * 10^7 = 20 * Y, Y = Y0 + Y1*m + Y2*m^2
    localparam int Y_W      = 26;
    localparam int Y0       = 654400;
    localparam int Y0_RND   = 654650;   // Y0 + 250, halves up before the divide by 500
    localparam int Y1       = 7195;
    localparam int Y2       = 38;
    localparam int OFFS_SCALE = 500;

    // floor(x / 500) = (x * RECIP_500) >> RECIP_SHIFT for x < 2^26
    localparam int RECIP_SHIFT = 35;
    localparam longint unsigned RECIP_500 = 64'd68719477;

    // pore water permittivity scaled: 87700 - 37 * t
    localparam int EW_W     = 17;
    localparam int EW_BASE  = 87700;
    localparam int EW_SLOPE = 37;

    localparam int NUM_SCALE = 1000;

    // limits seen on the result ports for any input pattern
    localparam logic [PERM_W-1:0] PERM_MIN = 17'd1309;
    localparam logic [PERM_W-1:0] PERM_MAX = 17'd95567;
    localparam int CENTI_HI = 7000;

endpackage

FILE: sv/soil_pore_water_ec_convert.sv
// Soil pore water conductivity converter (Hilhorst model).
//
// Input channel: present moisture_tenths, temperature_tenths and
// bulk_conductivity with start; the reading transfers at a rising edge where
// start is high and busy is low. busy is high only in the first cycle after
// reset, so one reading can transfer in every cycle.
// Result channel: water_content_centi, bulk_permittivity_milli,
// pore_conductivity and pore_valid are shown for one cycle with strobe high.
// A reading gives its result with strobe high once it has passed every
// stage of the pipeline. Results come out in input order.
// The receiver cannot stall; the pipeline has no back pressure at all.
// The pore conductivity divider takes one restoring step per quotient bit,
// in 20 stages, behind five front stages and one output stage.
// Configuration: cfg_data transfers when cfg_valid and cfg_ready are high
// and sets the substrate permittivity offset in thousandths; write it only
// while no reading is in flight. cfg_ready follows !busy.
// Reset: clears all stage valid bits, loads the offset with 4100 (4.1)
// and holds busy high until the first clock after reset.
module soil_pore_water_ec_convert
    import spwec_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [MOIST_W-1:0]        moisture_tenths,
    input  logic signed [TEMP_W-1:0]  temperature_tenths,
    input  logic [BULK_W-1:0]         bulk_conductivity,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [OFFS_W-1:0]         cfg_data,
    output logic                      strobe,
    output logic signed [CENTI_W-1:0] water_content_centi,
    output logic [PERM_W-1:0]         bulk_permittivity_milli,
    output logic [PORE_W-1:0]         pore_conductivity,
    output logic                      pore_valid
);

    // ------------------------------------------------------------------
    // Widths of the water content datapath, all following FRAC_BITS
    // ------------------------------------------------------------------
    localparam int HW    = FRAC_BITS + 7;       // h = moisture percent in Q(F)
    localparam int HH_W  = 2 * HW;              // h * h
    localparam int H2_W  = HH_W - FRAC_BITS;    // rounded h^2
    localparam int AW    = FRAC_BITS - 7;       // coefficient A
    localparam int BW    = FRAC_BITS;           // coefficient B
    localparam int BH_W  = BW + HW;             // B * h
    localparam int AH_W  = AW + H2_W;           // A * h^2
    localparam int DF_W  = BH_W + 1;            // signed difference
    localparam int VWW   = FRAC_BITS + 9;       // vwc in Q(F), signed
    localparam int PW    = VWW + 7;             // vwc * 100, signed
    localparam int Q10_W = 7;                   // moisture / 10
    localparam int PM_W  = 53;                  // reciprocal product
    localparam int NW    = 43;                  // divider dividend
    localparam int DV_W  = Y_W + 1;             // divider divisor
    localparam int D_W   = Y_W + 1;             // signed denominator
    localparam int CMP_W = DV_W + DIV_BITS;     // divider compare width
    localparam int OF5_W = 24;                  // 500 * offset
    localparam int CEN_IDX = 4;                 // divider slot where centi is done

    // Q(F) coefficients, rounded half up
    localparam logic [63:0] DEC12 = 64'd1000000000000;
    localparam logic [63:0] A64 = ((64'd2084449546 << FRAC_BITS) + DEC12 / 2) / DEC12;
    localparam logic [63:0] B64 = ((64'd875839580382 << FRAC_BITS) + DEC12 / 2) / DEC12;
    localparam logic [63:0] C64 = ((64'd7765958483 << FRAC_BITS) + DEC12 / 2) / DEC12;
    localparam logic [AW-1:0]  COEF_A   = AW'(A64);
    localparam logic [BW-1:0]  COEF_B   = BW'(B64);
    localparam logic [VWW-1:0] COEF_C_V = VWW'(C64);

    // fraction of h for moisture remainder r = m mod 10
    localparam logic [FRAC_BITS-1:0] HFRAC [10] = '{
        FRAC_BITS'(((64'd0 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd4 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd5 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd6 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd7 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd8 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10)
    };

    localparam logic [HH_W-1:0]        HALF_HH = HH_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [DF_W-1:0] HALF_DF = DF_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PW-1:0]   HALF_PW = PW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PW-1:0]   HUNDRED = PW'(100);

    // ------------------------------------------------------------------
    // Control: busy, offset register, stage valid bits
    // ------------------------------------------------------------------
    logic                  busy_reg;
    logic [OFFS_W-1:0]     offset_reg;
    logic [OFFS_W-1:0]     offset_next;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic                  in_xfer;
    logic                  cfg_xfer;

    assign in_xfer  = start && !busy_reg;
    assign cfg_xfer = cfg_valid && cfg_ready;

    always_comb
    begin
        offset_next = cfg_xfer ? cfg_data : offset_reg;
        // advance the valid bits every cycle: nothing downstream stalls
        vld_next    = {vld_reg[PIPE_DEPTH-2:0], in_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            offset_reg <= OFFSET_RESET;
            vld_reg    <= '0;
        end
        else
        begin
            busy_reg   <= 1'b0;
            offset_reg <= offset_next;
            vld_reg    <= vld_next;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    // ------------------------------------------------------------------
    // Stage 1: split moisture into tens, square it, pore permittivity
    // ------------------------------------------------------------------
    logic [MOIST_W-1:0]   m_s1_reg;
    logic [2*MOIST_W-1:0] m2_s1_reg;
    logic [Q10_W-1:0]     q10_s1_reg;
    logic [EW_W-1:0]      ew_s1_reg;
    logic [BULK_W-1:0]    sb_s1_reg;

    logic [17:0]          q10_prod;
    logic signed [17:0]   t_ext;
    logic signed [17:0]   ew_full;

    always_comb
    begin
        // floor(m / 10) as (m * 205) >> 11, exact for m below 1029
        q10_prod = 18'(moisture_tenths) * 18'(205);
        t_ext    = {{(18 - TEMP_W){temperature_tenths[TEMP_W-1]}}, temperature_tenths};
        ew_full  = $signed(18'(EW_BASE)) - $signed(18'(EW_SLOPE)) * t_ext;
    end

    always_ff @(posedge clk)
    begin
        m_s1_reg   <= moisture_tenths;
        m2_s1_reg  <= (2*MOIST_W)'(moisture_tenths) * (2*MOIST_W)'(moisture_tenths);
        q10_s1_reg <= q10_prod[17:11];
        ew_s1_reg  <= ew_full[EW_W-1:0];
        sb_s1_reg  <= bulk_conductivity;
    end

    // ------------------------------------------------------------------
    // Stage 2: h in Q(F), permittivity polynomial, ew * sb
    // ------------------------------------------------------------------
    logic [HW-1:0]  h_s2_reg;
    logic [Y_W-1:0] y_s2_reg;
    logic [Y_W-1:0] yp_s2_reg;
    logic [31:0]    w_s2_reg;

    logic [MOIST_W-1:0] rem10_full;
    logic [3:0]         rem10;
    logic [Y_W-1:0]     y_var;

    always_comb
    begin
        rem10_full = m_s1_reg - MOIST_W'(q10_s1_reg) * MOIST_W'(10);
        rem10      = rem10_full[3:0];
        y_var      = Y_W'(Y1) * Y_W'(m_s1_reg) + Y_W'(Y2) * Y_W'(m2_s1_reg);
    end

    always_ff @(posedge clk)
    begin
        h_s2_reg  <= {q10_s1_reg, HFRAC[rem10]};
        y_s2_reg  <= Y_W'(Y0) + y_var;
        yp_s2_reg <= Y_W'(Y0_RND) + y_var;
        w_s2_reg  <= 32'(ew_s1_reg) * 32'(sb_s1_reg);
    end

    // ------------------------------------------------------------------
    // Stage 3: h^2, B*h, bulk permittivity, signed denominator
    // ------------------------------------------------------------------
    logic [HH_W-1:0]       hh_s3_reg;
    logic [BH_W-1:0]       bh_s3_reg;
    logic [PERM_W-1:0]     perm_s3_reg;
    logic signed [D_W-1:0] d_s3_reg;
    logic [31:0]           w_s3_reg;

    logic [PM_W-1:0]  pm_prod;
    logic [OF5_W-1:0] off500;

    always_comb
    begin
        pm_prod = PM_W'(yp_s2_reg) * PM_W'(RECIP_500);
        off500  = OF5_W'(offset_reg) * OF5_W'(OFFS_SCALE);
    end

    always_ff @(posedge clk)
    begin
        hh_s3_reg   <= HH_W'(h_s2_reg) * HH_W'(h_s2_reg);
        bh_s3_reg   <= BH_W'(COEF_B) * BH_W'(h_s2_reg);
        perm_s3_reg <= pm_prod[RECIP_SHIFT+PERM_W-1:RECIP_SHIFT];
        d_s3_reg    <= $signed({1'b0, y_s2_reg}) - $signed({{(D_W - OF5_W){1'b0}}, off500});
        w_s3_reg    <= w_s2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: round h^2, build dividend and divisor
    //   q = floor((1000*W + D) / (2*D)) equals round(num / den)
    // ------------------------------------------------------------------
    logic [H2_W-1:0]   h2_s4_reg;
    logic [BH_W-1:0]   bh_s4_reg;
    logic [PERM_W-1:0] perm_s4_reg;
    logic [NW-1:0]     n_s4_reg;
    logic [DV_W-1:0]   v_s4_reg;
    logic              bad_s4_reg;

    logic [HH_W-1:0] hh_sum;

    assign hh_sum = hh_s3_reg + HALF_HH;

    always_ff @(posedge clk)
    begin
        h2_s4_reg   <= hh_sum[HH_W-1:FRAC_BITS];
        bh_s4_reg   <= bh_s3_reg;
        perm_s4_reg <= perm_s3_reg;
        n_s4_reg    <= NW'(w_s3_reg) * NW'(NUM_SCALE) + NW'(d_s3_reg[Y_W-1:0]);
        v_s4_reg    <= {d_s3_reg[Y_W-1:0], 1'b0};
        bad_s4_reg  <= d_s3_reg[D_W-1] || (d_s3_reg == '0);
    end

    // ------------------------------------------------------------------
    // Stage 5: A*h^2, overflow check; divider slot 0 is loaded here
    // ------------------------------------------------------------------
    logic [AH_W-1:0] ah2_s5_reg;
    logic [BH_W-1:0] bh_s5_reg;

    logic [NW-1:0]     drem_reg  [DIV_BITS];
    logic [DV_W-1:0]   dv_reg    [DIV_BITS];
    logic [PORE_W-1:0] dquo_reg  [DIV_BITS+1];
    logic              dsat_reg  [DIV_BITS+1];
    logic [PERM_W-1:0] dperm_reg [DIV_BITS+1];

    logic ovf;

    // quotient of 2^20 or more saturates
    assign ovf = CMP_W'(n_s4_reg) >= (CMP_W'(v_s4_reg) << DIV_BITS);

    always_ff @(posedge clk)
    begin
        ah2_s5_reg   <= AH_W'(COEF_A) * AH_W'(h2_s4_reg);
        bh_s5_reg    <= bh_s4_reg;
        drem_reg[0]  <= n_s4_reg;
        dv_reg[0]    <= v_s4_reg;
        dquo_reg[0]  <= '0;
        dsat_reg[0]  <= bad_s4_reg || ovf;
        dperm_reg[0] <= perm_s4_reg;
    end

    // ------------------------------------------------------------------
    // Stages 6 to 9: finish water content, then hold it beside the divider
    // ------------------------------------------------------------------
    logic signed [DF_W-1:0] diff_s6_reg;
    logic signed [VWW-1:0]  vwc_s7_reg;
    logic signed [PW-1:0]   p100_s8_reg;
    logic [CENTI_W-1:0]     cen_reg [CEN_IDX:DIV_BITS];

    logic signed [DF_W-1:0] diff_sum;
    logic [DF_W-FRAC_BITS-1:0] vwc_rnd;
    logic signed [PW-1:0]   p100_sum;

    always_comb
    begin
        diff_sum = diff_s6_reg + HALF_DF;
        vwc_rnd  = diff_sum[DF_W-1:FRAC_BITS];
        p100_sum = p100_s8_reg + HALF_PW;
    end

    always_ff @(posedge clk)
    begin
        diff_s6_reg      <= $signed({1'b0, bh_s5_reg}) - $signed({1'b0, ah2_s5_reg});
        vwc_s7_reg       <= $signed({vwc_rnd[DF_W-FRAC_BITS-1], vwc_rnd}) - $signed(COEF_C_V);
        p100_s8_reg      <= $signed({{(PW - VWW){vwc_s7_reg[VWW-1]}}, vwc_s7_reg}) * HUNDRED;
        cen_reg[CEN_IDX] <= p100_sum[FRAC_BITS+CENTI_W-1:FRAC_BITS];
    end

    for (genvar k = CEN_IDX + 1; k <= DIV_BITS; k++)
    begin : g_cen_dly
        always_ff @(posedge clk)
        begin
            cen_reg[k] <= cen_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stages 6 to 25: restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_div
        localparam int BIT = DIV_BITS - 1 - j;

        logic [CMP_W-1:0] rem_ext;
        logic [CMP_W-1:0] dvs_sh;
        logic [CMP_W-1:0] rem_sub;
        logic             ge;

        always_comb
        begin
            rem_ext = CMP_W'(drem_reg[j]);
            dvs_sh  = CMP_W'(dv_reg[j]) << BIT;
            ge      = rem_ext >= dvs_sh;
            rem_sub = rem_ext - dvs_sh;
        end

        always_ff @(posedge clk)
        begin
            dquo_reg[j+1]  <= dquo_reg[j] | (PORE_W'(ge) << BIT);
            dsat_reg[j+1]  <= dsat_reg[j];
            dperm_reg[j+1] <= dperm_reg[j];
        end

        if (j < DIV_BITS - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                drem_reg[j+1] <= ge ? rem_sub[NW-1:0] : drem_reg[j];
                dv_reg[j+1]   <= dv_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 26: output register, saturate the pore EC
    // ------------------------------------------------------------------
    logic [CENTI_W-1:0] cen_o_reg;
    logic [PERM_W-1:0]  perm_o_reg;
    logic [PORE_W-1:0]  pore_o_reg;
    logic               pvld_o_reg;

    always_ff @(posedge clk)
    begin
        cen_o_reg  <= cen_reg[DIV_BITS];
        perm_o_reg <= dperm_reg[DIV_BITS];
        pore_o_reg <= dsat_reg[DIV_BITS] ? PORE_MAX : dquo_reg[DIV_BITS];
        pvld_o_reg <= !dsat_reg[DIV_BITS];
    end

    assign strobe                  = vld_reg[PIPE_DEPTH-1];
    assign water_content_centi     = $signed(cen_o_reg);
    assign bulk_permittivity_milli = perm_o_reg;
    assign pore_conductivity       = pore_o_reg;
    assign pore_valid              = pvld_o_reg;

endmodule

FILE: sv/spwec_checker.sv
`include "soil_pore_water_ec_convert_assert.svh"

module spwec_checker
    import spwec_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      strobe,
    input logic signed [CENTI_W-1:0] water_content_centi,
    input logic [PERM_W-1:0]         bulk_permittivity_milli,
    input logic [PORE_W-1:0]         pore_conductivity,
    input logic                      pore_valid
);

    // a flagged result always carries the saturated EC
    `SPWEC_ASSERT_IMP(a_sat_value, strobe && !pore_valid, pore_conductivity == PORE_MAX, "invalid pore EC not saturated")

    // permittivity stays inside what the moisture polynomial can give
    `SPWEC_ASSERT_IMP(a_perm_range, strobe, (bulk_permittivity_milli >= PERM_MIN) && (bulk_permittivity_milli <= PERM_MAX), "bulk permittivity out of range")

    // water content is a rising quadratic over the moisture field
    `SPWEC_ASSERT_IMP(a_vwc_range, strobe, (water_content_centi >= -15'sd1) && (water_content_centi <= 15'(CENTI_HI)), "water content out of range")

endmodule

bind soil_pore_water_ec_convert spwec_checker u_spwec_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .strobe                  (strobe),
    .water_content_centi     (water_content_centi),
    .bulk_permittivity_milli (bulk_permittivity_milli),
    .pore_conductivity       (pore_conductivity),
    .pore_valid              (pore_valid)
);
